FILE: hw/rtl/btlv_pkg.sv
// ----------------------------------------------------------------------------
// btlv_pkg
// shared types, codes and helper functions of the ber tlv stream parser
// ----------------------------------------------------------------------------
package btlv_pkg;

   localparam int MAX_LENGTH_BYTES = 8;

   localparam int IN_DATA_W  = 8;
   localparam int OUT_DATA_W = 184;
   localparam int OUT_USER_W = 3;

   // parser phases
   localparam logic [1:0] PH_TAG      = 2'd0;
   localparam logic [1:0] PH_LEN      = 2'd1;
   localparam logic [1:0] PH_LENBYTES = 2'd2;
   localparam logic [1:0] PH_CONTENT  = 2'd3;

   // result kinds
   localparam logic [2:0] EV_HEADER = 3'd0;
   localparam logic [2:0] EV_DATA   = 3'd1;
   localparam logic [2:0] EV_INT    = 3'd2;
   localparam logic [2:0] EV_ARC    = 3'd3;
   localparam logic [2:0] EV_ERR    = 3'd4;

   // error codes
   localparam logic [2:0] ERR_HIGH_TAG  = 3'd0;
   localparam logic [2:0] ERR_BAD_LEN   = 3'd1;
   localparam logic [2:0] ERR_EMPTY_INT = 3'd2;
   localparam logic [2:0] ERR_EMPTY_OID = 3'd3;
   localparam logic [2:0] ERR_TRUNC_OID = 3'd4;
   localparam logic [2:0] ERR_STREAM_END = 3'd5;

   // universal tag numbers
   localparam logic [4:0] TAG_INTEGER = 5'd2;
   localparam logic [4:0] TAG_OID     = 5'd6;
   localparam logic [4:0] TAG_HIGH    = 5'h1F;

   localparam int RESULTS_MAX = 3;

   typedef struct packed {
      logic [2:0]  kind;
      logic [1:0]  tag_class;
      logic        is_constructed;
      logic [4:0]  tag_number;
      logic [63:0] content_length;
      logic [63:0] int_value;
      logic [31:0] oid_arc;
      logic [7:0]  data_byte;
      logic [2:0]  error_code;
   } evt_type;

   typedef struct packed {
      logic [1:0]                    count;
      evt_type [RESULTS_MAX-1:0]     ev;
   } bundle_type;

   function automatic evt_type tag_ev(input logic [2:0]  kind,
                                      input logic [1:0]  cls,
                                      input logic        con,
                                      input logic [4:0]  num,
                                      input logic [63:0] len,
                                      input logic [63:0] iv,
                                      input logic [31:0] arc,
                                      input logic [7:0]  data);
      evt_type e;
      e.kind           = kind;
      e.tag_class      = cls;
      e.is_constructed = con;
      e.tag_number     = num;
      e.content_length = len;
      e.int_value      = iv;
      e.oid_arc        = arc;
      e.data_byte      = data;
      e.error_code     = 3'd0;
      return e;
   endfunction

   function automatic evt_type err_ev(input logic [2:0] code);
      evt_type e;
      e            = '0;
      e.kind       = EV_ERR;
      e.error_code = code;
      return e;
   endfunction

   // quotient of a byte by 40, by threshold compares
   function automatic logic [2:0] div40(input logic [7:0] b);
      logic [2:0] q;
      q = 3'(b >= 8'd40) + 3'(b >= 8'd80) + 3'(b >= 8'd120) + 3'(b >= 8'd160)
        + 3'(b >= 8'd200) + 3'(b >= 8'd240);
      return q;
   endfunction

endpackage

FILE: hw/rtl/btlv_decode.sv
// ----------------------------------------------------------------------------
// btlv_decode
// parser state and per-byte decode into a bundle of up to three results
// ----------------------------------------------------------------------------
module btlv_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          in_byte,
   input  logic                frame_end,
   output btlv_pkg::bundle_type bundle
);

   logic [1:0]  phase_ff, phase_in;
   logic [1:0]  cls_ff, cls_in;
   logic        con_ff, con_in;
   logic [4:0]  num_ff, num_in;
   logic [3:0]  lleft_ff, lleft_in;
   logic [63:0] lacc_ff, lacc_in;
   logic [63:0] cleft_ff, cleft_in;
   logic [63:0] iacc_ff, iacc_in;
   logic [31:0] aacc_ff, aacc_in;
   logic        first_ff, first_in;

   logic is_int, is_oid;

   assign is_int = (cls_ff == 2'd0) && !con_ff && (num_ff == btlv_pkg::TAG_INTEGER);
   assign is_oid = (cls_ff == 2'd0) && !con_ff && (num_ff == btlv_pkg::TAG_OID);

   always_comb begin
      logic [1:0]  k;
      logic        finish;
      logic        last;
      logic        trunc;
      logic [6:0]  n;
      logic [63:0] ibase;
      logic [31:0] arc_t;
      logic [2:0]  q;
      logic [7:0]  r;
      btlv_pkg::evt_type [btlv_pkg::RESULTS_MAX-1:0] ev;

      k        = 2'd0;
      finish   = 1'b0;
      last     = 1'b0;
      trunc    = 1'b0;
      n        = in_byte[6:0];
      ibase    = '0;
      arc_t    = '0;
      q        = btlv_pkg::div40(in_byte);
      r        = in_byte - 8'(8'(q) * 8'd40);
      ev       = '0;
      phase_in = phase_ff;
      cls_in   = cls_ff;
      con_in   = con_ff;
      num_in   = num_ff;
      lleft_in = lleft_ff;
      lacc_in  = lacc_ff;
      cleft_in = cleft_ff;
      iacc_in  = iacc_ff;
      aacc_in  = aacc_ff;
      first_in = first_ff;

      unique case (phase_ff)
         btlv_pkg::PH_TAG: begin
            if (in_byte[4:0] == btlv_pkg::TAG_HIGH) begin
               ev[k] = btlv_pkg::err_ev(btlv_pkg::ERR_HIGH_TAG);
               k = k + 2'd1;
               phase_in = btlv_pkg::PH_TAG;
            end else begin
               cls_in   = in_byte[7:6];
               con_in   = in_byte[5];
               num_in   = in_byte[4:0];
               phase_in = btlv_pkg::PH_LEN;
               if (frame_end) begin
                  ev[k] = btlv_pkg::err_ev(btlv_pkg::ERR_STREAM_END);
                  k = k + 2'd1;
                  phase_in = btlv_pkg::PH_TAG;
               end
            end
         end
         btlv_pkg::PH_LEN: begin
            if (!in_byte[7]) begin
               lacc_in = {56'd0, in_byte};
               finish  = 1'b1;
            end else if (n == 7'd0 || n > 7'(btlv_pkg::MAX_LENGTH_BYTES)) begin
               ev[k] = btlv_pkg::err_ev(btlv_pkg::ERR_BAD_LEN);
               k = k + 2'd1;
               phase_in = btlv_pkg::PH_TAG;
            end else begin
               lleft_in = n[3:0];
               lacc_in  = '0;
               phase_in = btlv_pkg::PH_LENBYTES;
               if (frame_end) begin
                  ev[k] = btlv_pkg::err_ev(btlv_pkg::ERR_STREAM_END);
                  k = k + 2'd1;
                  phase_in = btlv_pkg::PH_TAG;
               end
            end
         end
         btlv_pkg::PH_LENBYTES: begin
            lacc_in  = {lacc_ff[55:0], in_byte};
            lleft_in = lleft_ff - 4'd1;
            if (lleft_in == 4'd0) begin
               finish = 1'b1;
            end else if (frame_end) begin
               ev[k] = btlv_pkg::err_ev(btlv_pkg::ERR_STREAM_END);
               k = k + 2'd1;
               phase_in = btlv_pkg::PH_TAG;
            end
         end
         btlv_pkg::PH_CONTENT: begin
            if (cleft_ff == 64'd0) begin
               phase_in = btlv_pkg::PH_TAG;
            end else begin
               cleft_in = cleft_ff - 64'd1;
               last     = (cleft_ff == 64'd1);
               first_in = 1'b0;
               if (is_int) begin
                  ibase   = first_ff ? {64{in_byte[7]}} : iacc_ff;
                  iacc_in = {ibase[55:0], in_byte};
                  if (last) begin
                     ev[k] = btlv_pkg::tag_ev(btlv_pkg::EV_INT, cls_ff, con_ff, num_ff,
                                              64'd0, iacc_in, 32'd0, 8'd0);
                     k = k + 2'd1;
                  end
               end else if (is_oid) begin
                  if (first_ff) begin
                     ev[k] = btlv_pkg::tag_ev(btlv_pkg::EV_ARC, cls_ff, con_ff, num_ff,
                                              64'd0, 64'd0, {29'd0, q}, 8'd0);
                     k = k + 2'd1;
                     ev[k] = btlv_pkg::tag_ev(btlv_pkg::EV_ARC, cls_ff, con_ff, num_ff,
                                              64'd0, 64'd0, {24'd0, r}, 8'd0);
                     k = k + 2'd1;
                  end else begin
                     arc_t = {aacc_ff[24:0], in_byte[6:0]};
                     if (!in_byte[7]) begin
                        ev[k] = btlv_pkg::tag_ev(btlv_pkg::EV_ARC, cls_ff, con_ff, num_ff,
                                                 64'd0, 64'd0, arc_t, 8'd0);
                        k = k + 2'd1;
                        aacc_in = '0;
                     end else begin
                        aacc_in = arc_t;
                     end
                  end
                  if (last && in_byte[7]) begin
                     ev[k] = btlv_pkg::err_ev(btlv_pkg::ERR_TRUNC_OID);
                     k = k + 2'd1;
                     phase_in = btlv_pkg::PH_TAG;
                     trunc = 1'b1;
                  end
               end else begin
                  ev[k] = btlv_pkg::tag_ev(btlv_pkg::EV_DATA, cls_ff, con_ff, num_ff,
                                           64'd0, 64'd0, 32'd0, in_byte);
                  k = k + 2'd1;
               end
               if (!trunc) begin
                  if (last) begin
                     phase_in = btlv_pkg::PH_TAG;
                  end else if (frame_end) begin
                     ev[k] = btlv_pkg::err_ev(btlv_pkg::ERR_STREAM_END);
                     k = k + 2'd1;
                     phase_in = btlv_pkg::PH_TAG;
                  end
               end
            end
         end
      endcase

      // header completion, shared by short and long length forms
      if (finish) begin
         ev[k] = btlv_pkg::tag_ev(btlv_pkg::EV_HEADER, cls_ff, con_ff, num_ff,
                                  lacc_in, 64'd0, 32'd0, 8'd0);
         k = k + 2'd1;
         if (con_ff) begin
            phase_in = btlv_pkg::PH_TAG;
            if (frame_end && lacc_in != 64'd0) begin
               ev[k] = btlv_pkg::err_ev(btlv_pkg::ERR_STREAM_END);
               k = k + 2'd1;
            end
         end else if (lacc_in == 64'd0) begin
            phase_in = btlv_pkg::PH_TAG;
            if (is_int) begin
               ev[k] = btlv_pkg::err_ev(btlv_pkg::ERR_EMPTY_INT);
               k = k + 2'd1;
            end else if (is_oid) begin
               ev[k] = btlv_pkg::err_ev(btlv_pkg::ERR_EMPTY_OID);
               k = k + 2'd1;
            end
         end else begin
            phase_in = btlv_pkg::PH_CONTENT;
            cleft_in = lacc_in;
            first_in = 1'b1;
            iacc_in  = '0;
            aacc_in  = '0;
            if (frame_end) begin
               ev[k] = btlv_pkg::err_ev(btlv_pkg::ERR_STREAM_END);
               k = k + 2'd1;
               phase_in = btlv_pkg::PH_TAG;
            end
         end
      end

      if (frame_end) begin
         phase_in = btlv_pkg::PH_TAG;
      end

      bundle.count = k;
      bundle.ev    = ev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= btlv_pkg::PH_TAG;
         cls_ff   <= '0;
         con_ff   <= 1'b0;
         num_ff   <= '0;
         lleft_ff <= '0;
         lacc_ff  <= '0;
         cleft_ff <= '0;
         iacc_ff  <= '0;
         aacc_ff  <= '0;
         first_ff <= 1'b1;
      end else if (accept) begin
         phase_ff <= phase_in;
         cls_ff   <= cls_in;
         con_ff   <= con_in;
         num_ff   <= num_in;
         lleft_ff <= lleft_in;
         lacc_ff  <= lacc_in;
         cleft_ff <= cleft_in;
         iacc_ff  <= iacc_in;
         aacc_ff  <= aacc_in;
         first_ff <= first_in;
      end
   end

endmodule

FILE: hw/rtl/btlv_outq.sv
// ----------------------------------------------------------------------------
// btlv_outq
// result register holding one byte's bundle and handing it out one per transfer
// ----------------------------------------------------------------------------
module btlv_outq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  btlv_pkg::bundle_type bundle,
   output logic                 free,
   output logic                 out_valid,
   input  logic                 out_ready,
   output btlv_pkg::evt_type    out_ev,
   output logic                 out_last
);

   btlv_pkg::evt_type [btlv_pkg::RESULTS_MAX-1:0] ev_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic [1:0] idx_ff, idx_in;
   logic       is_last;
   logic       xfer;

   assign out_valid = (cnt_ff != 2'd0);
   assign is_last   = (idx_ff == cnt_ff - 2'd1);
   assign xfer      = out_valid && out_ready;
   assign free      = !out_valid || (out_ready && is_last);
   assign out_ev    = ev_ff[idx_ff];
   assign out_last  = is_last;

   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      priority if (load) begin
         cnt_in = bundle.count;
         idx_in = 2'd0;
      end else if (xfer && is_last) begin
         cnt_in = 2'd0;
         idx_in = 2'd0;
      end else if (xfer) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ev_ff <= bundle.ev;
      end
   end

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd0 |-> idx_ff < cnt_ff)
      else $error("result index beyond bundle count");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> (cnt_ff == 2'd0) || (out_ready && is_last))
      else $error("bundle overwritten before delivery");

   a_idx_advance: assert property (@(posedge clock) disable iff (reset)
      xfer && !is_last && !load |=> idx_ff == $past(idx_ff) + 2'd1)
      else $error("result index did not advance after transfer");

   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> $stable(idx_ff) && $stable(cnt_ff))
      else $error("pending results changed during stall");

endmodule

FILE: hw/rtl/ber_tlv_stream_parser.sv
// ----------------------------------------------------------------------------
// ber_tlv_stream_parser
// streaming asn.1 ber/der tag-length-value decoder, one byte per transfer
// ----------------------------------------------------------------------------
// The req channel carries the encoded stream, one byte per transfer, with
// req_tlast on the last byte of a frame. Each byte yields zero to three
// results on the rsp channel: headers, content bytes, integer values, oid
// arcs and errors, in stream order; rsp_tlast marks the final result of a
// byte and rsp_tuser gives its kind.
// The byte is decoded in the cycle it is taken and its results are in the
// result register on the next edge, where the first of them shows. The result
// register hands out one result per cycle while rsp_tready is high, so a byte
// with several results holds off the input until its last one leaves; a byte
// with one result or none goes through every cycle while rsp_tready is high.
// A new byte is taken in the same cycle as the last result of the previous one.
// When the receiver stalls the pending result holds and req_tready stays low
// while it cannot leave.
// Reset empties the result register and returns the parser to expecting a
// tag byte with all accumulators cleared.
// ----------------------------------------------------------------------------
module ber_tlv_stream_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [btlv_pkg::IN_DATA_W-1:0]    req_tdata,   // in_byte[7:0]
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tag_class[1:0], is_constructed[2], tag_number[7:3], content_length[71:8],
   // int_value[135:72], oid_arc[167:136], data_byte[175:168],
   // error_code[178:176], zero[183:179]
   output logic [btlv_pkg::OUT_DATA_W-1:0]   rsp_tdata,
   output logic [btlv_pkg::OUT_USER_W-1:0]   rsp_tuser,   // event_kind[2:0]
   output logic                              rsp_tlast
);

   btlv_pkg::bundle_type bundle;
   btlv_pkg::evt_type    out_ev;
   logic                 free;
   logic                 accept;

   assign req_tready = free;
   assign accept     = req_tvalid && req_tready;

   btlv_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_tdata),
      .frame_end (req_tlast),
      .bundle    (bundle)
   );

   btlv_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .bundle    (bundle),
      .free      (free),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_ev    (out_ev),
      .out_last  (rsp_tlast)
   );

   assign rsp_tuser = out_ev.kind;
   assign rsp_tdata = {5'd0, out_ev.error_code, out_ev.data_byte, out_ev.oid_arc,
                       out_ev.int_value, out_ev.content_length, out_ev.tag_number,
                       out_ev.is_constructed, out_ev.tag_class};

endmodule
